// ===== design/stfc_pkg.sv =====
// Shared types and constants for the sorted table floor/ceiling search block.
package stfc_pkg;

  localparam int DATA_W              = 32;
  localparam int MODE_W              = 2;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Transaction modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Value reported when no floor or ceiling exists
  localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } stfc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] floor_value;
    logic                     floor_found;
    logic signed [DATA_W-1:0] ceiling_value;
    logic                     ceiling_found;
  } stfc_out_t;

endpackage

// ===== design/sorted_table_floor_ceiling_search.sv =====
// Sorted table floor/ceiling search: top level with output register.
// Values loaded in ascending order are appended to an on-chip table of
// TABLE_DEPTH entries (loads beyond a full table are dropped); a clear empties
// it at once. A query binary-searches the loaded entries, one probe per clock
// through the single read port of the table memory, and returns the floor and
// ceiling of the key with found flags (value -1 when absent). Loads, clears and
// the unused mode give no result. A query is accepted in S_IDLE, probes in
// S_PROBE until it hits the key or its range is empty, and hands its result
// to the output register from S_DONE; an empty table goes straight to S_DONE.
// The output register holds a finished result while the next transaction is
// already accepted.
module sorted_table_floor_ceiling_search #(
  parameter int TABLE_DEPTH = stfc_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stfc_pkg::stfc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stfc_pkg::stfc_out_t out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic signed [stfc_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]                      mem_raddr;
  logic signed [stfc_pkg::DATA_W-1:0] mem_rdata;

  logic                res_valid;
  logic                res_ready;
  stfc_pkg::stfc_out_t res;

  logic                out_valid_r, out_valid_nxt;
  stfc_pkg::stfc_out_t out_data_r, out_data_nxt;

  stfc_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stfc_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Output register: takes a result when empty or draining this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/stfc_table_mem.sv =====
// Table storage: one write port, one read port, registered read data.
module stfc_table_mem #(
  parameter int TABLE_DEPTH = stfc_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [stfc_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [stfc_pkg::DATA_W-1:0] rdata
);

  logic signed [stfc_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/stfc_search.sv =====
// Control sequencer: appends loads, clears the count, binary-searches on queries.
module stfc_search #(
  parameter int TABLE_DEPTH = stfc_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  stfc_pkg::stfc_in_t                 item,
  output logic                               res_valid,
  input  logic                               res_ready,
  output stfc_pkg::stfc_out_t                res,
  output logic                               mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]     mem_waddr,
  output logic signed [stfc_pkg::DATA_W-1:0] mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]     mem_raddr,
  input  logic signed [stfc_pkg::DATA_W-1:0] mem_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t                             state_r, state_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [CW-1:0]                      lo_r, lo_nxt;
  logic [CW-1:0]                      hi1_r, hi1_nxt;   // exclusive upper bound
  logic [CW-1:0]                      mid_r, mid_nxt;
  logic signed [stfc_pkg::DATA_W-1:0] key_r, key_nxt;
  stfc_pkg::stfc_out_t                res_r, res_nxt;

  logic          accept;
  logic [CW-1:0] mid_first;
  logic [CW-1:0] mid_a, mid_b;
  logic          cont_a, cont_b;
  logic          cmp_eq, cmp_gt;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res        = res_r;

  // Appends go straight to the memory at the fill position
  assign mem_we    = accept && (item.mode == stfc_pkg::MODE_LOAD) && (count_r < DEPTH_C);
  assign mem_waddr = count_r[AW-1:0];
  assign mem_wdata = item.value;

  // First probe sits at the middle of the loaded entries
  assign mid_first = (count_r - ONE_C) >> 1;

  // Probe compare against the entry read for mid_r
  assign cmp_eq = (mem_rdata == key_r);
  assign cmp_gt = (mem_rdata > key_r);

  // Next probe candidates, computed alongside the compare
  // a: entry above key, keep lower half; b: entry below key, keep upper half
  assign mid_a  = lo_r + ((mid_r - lo_r - ONE_C) >> 1);
  assign mid_b  = mid_r + ONE_C + ((hi1_r - mid_r - TWO_C) >> 1);
  assign cont_a = (lo_r < mid_r);
  assign cont_b = ((mid_r + ONE_C) < hi1_r);

  // Read address: first probe from the loaded count, later probes from the compare
  always_comb begin
    mem_raddr = mid_r[AW-1:0];
    if (state_r == S_IDLE) begin
      mem_raddr = mid_first[AW-1:0];
    end else if (state_r == S_PROBE) begin
      mem_raddr = cmp_gt ? mid_a[AW-1:0] : mid_b[AW-1:0];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi1_nxt   = hi1_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (item.mode == stfc_pkg::MODE_LOAD) begin
            if (count_r < DEPTH_C) begin
              count_nxt = count_r + ONE_C;
            end
          end else if (item.mode == stfc_pkg::MODE_CLEAR) begin
            count_nxt = '0;
          end else if (item.mode == stfc_pkg::MODE_QUERY) begin
            key_nxt                = item.value;
            lo_nxt                 = '0;
            hi1_nxt                = count_r;
            mid_nxt                = mid_first;
            res_nxt.floor_value    = stfc_pkg::NONE_VALUE;
            res_nxt.floor_found    = 1'b0;
            res_nxt.ceiling_value  = stfc_pkg::NONE_VALUE;
            res_nxt.ceiling_found  = 1'b0;
            state_nxt              = (count_r == '0) ? S_DONE : S_PROBE;
          end else begin
            // unused mode: dropped
            state_nxt = S_IDLE;
          end
        end
      end
      S_PROBE: begin
        priority if (cmp_eq) begin
          // exact hit is both floor and ceiling
          res_nxt.floor_value   = mem_rdata;
          res_nxt.floor_found   = 1'b1;
          res_nxt.ceiling_value = mem_rdata;
          res_nxt.ceiling_found = 1'b1;
          state_nxt             = S_DONE;
        end else if (cmp_gt) begin
          res_nxt.ceiling_value = mem_rdata;
          res_nxt.ceiling_found = 1'b1;
          hi1_nxt               = mid_r;
          mid_nxt               = mid_a;
          state_nxt             = cont_a ? S_PROBE : S_DONE;
        end else begin
          res_nxt.floor_value = mem_rdata;
          res_nxt.floor_found = 1'b1;
          lo_nxt              = mid_r + ONE_C;
          mid_nxt             = mid_b;
          state_nxt           = cont_b ? S_PROBE : S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r  <= lo_nxt;
    hi1_r <= hi1_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule
